/* hw/rtl/hrsp_pkg.sv */
package hrsp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
		logic       sink_stop;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  byte_class;
		logic [7:0]  out_byte;
		logic [9:0]  response_code;
		logic [1:0]  header_id;
		logic [31:0] bytes_left;
		logic        chunked;
	} out_item_t;

	typedef enum logic [2:0] {
		M_HEADER = 3'd0,
		M_EXPECT = 3'd1,
		M_CHDR   = 3'd2,
		M_CDATA  = 3'd3,
		M_STREAM = 3'd4,
		M_CLOSE  = 3'd5,
		M_ERROR  = 3'd6,
		M_SPARE  = 3'd7
	} mode_t;

	localparam logic [1:0] C_NONE  = 2'd0;
	localparam logic [1:0] C_LEN   = 2'd1;
	localparam logic [1:0] C_CHUNK = 2'd2;

	localparam logic [3:0] CL_SKIP    = 4'd0;
	localparam logic [3:0] CL_VERSION = 4'd1;
	localparam logic [3:0] CL_CODE    = 4'd2;
	localparam logic [3:0] CL_REASON  = 4'd3;
	localparam logic [3:0] CL_KEY     = 4'd4;
	localparam logic [3:0] CL_VALUE   = 4'd5;
	localparam logic [3:0] CL_PAIREND = 4'd6;
	localparam logic [3:0] CL_HDONE   = 4'd7;
	localparam logic [3:0] CL_CHUNKF  = 4'd8;
	localparam logic [3:0] CL_BODY    = 4'd9;
	localparam logic [3:0] CL_CLOSED  = 4'd10;
	localparam logic [3:0] CL_ERROR   = 4'd11;

	localparam logic [7:0] A_DONE  = 8'hC0;
	localparam logic [7:0] A_ERR   = 8'hC1;
	localparam logic [7:0] A_PAIR  = 8'hC4;
	localparam logic [7:0] A_VER   = 8'h80;
	localparam logic [7:0] A_CODE  = 8'h81;
	localparam logic [7:0] A_RSN   = 8'h82;
	localparam logic [7:0] A_KEY   = 8'h84;
	localparam logic [7:0] A_VAL0  = 8'h87;
	localparam logic [7:0] A_VAL1  = 8'h88;
	localparam logic [7:0] A_CSTEP = 8'h83;
	localparam logic [7:0] A_CFIRST = 8'h01;

	// classified byte handed from the front to the back
	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] col_hdr;
		logic [1:0] col_chk;
		logic [3:0] hex_val;
		logic       is_digit;
		logic [7:0] low_byte;
		logic       start_req;
		logic       sink_stop;
	} cls_item_t;

	function automatic logic [7:0] hdr_lookup(input logic [3:0] st, input logic [2:0] col);
		logic [7:0] t [0:87];
		t = '{
			8'h80, 8'd1, 8'hC1, 8'hC1, 8'd1, 8'h80, 8'h80, 8'hC1,
			8'h81, 8'd2, 8'hC1, 8'hC1, 8'd2, 8'd1, 8'd1, 8'hC1,
			8'h82, 8'h82, 8'd4, 8'd3, 8'h82, 8'h82, 8'h82, 8'hC1,
			8'hC1, 8'hC1, 8'd4, 8'hC1, 8'hC1, 8'hC1, 8'hC1, 8'hC1,
			8'h84, 8'hC1, 8'hC0, 8'd5, 8'hC1, 8'hC1, 8'd6, 8'hC1,
			8'hC1, 8'hC1, 8'hC0, 8'hC1, 8'hC1, 8'hC1, 8'hC1, 8'hC1,
			8'h87, 8'd6, 8'hC1, 8'hC1, 8'd6, 8'h87, 8'h87, 8'hC1,
			8'h87, 8'h87, 8'hC4, 8'd10, 8'h87, 8'h88, 8'h87, 8'hC1,
			8'h87, 8'h88, 8'd6, 8'd9, 8'h88, 8'h88, 8'h87, 8'hC1,
			8'hC1, 8'hC1, 8'd6, 8'hC1, 8'hC1, 8'hC1, 8'hC1, 8'hC1,
			8'hC1, 8'hC1, 8'hC4, 8'hC1, 8'hC1, 8'hC1, 8'hC1, 8'hC1};
		if (st > 4'd10) return A_ERR;
		return t[{3'd0, st} * 7'd8 + {4'd0, col}];
	endfunction

	function automatic logic [7:0] chk_lookup(input logic [3:0] st, input logic [1:0] col);
		logic [7:0] t [0:19];
		t = '{
			8'hC1, 8'hC1, 8'hC1, 8'd1,
			8'hC1, 8'hC1, 8'd2, 8'h81,
			8'hC1, 8'h83, 8'hC1, 8'hC1,
			8'hC1, 8'hC1, 8'd4, 8'hC1,
			8'hC1, 8'hC0, 8'hC1, 8'hC1};
		if (st > 4'd4) return A_ERR;
		return t[{1'b0, st} * 5'd4 + {3'd0, col}];
	endfunction

	function automatic logic [7:0] key_char(input logic [1:0] k, input logic [4:0] p);
		logic [8*17-1:0] s;
		logic [4:0]      n;
		case (k)
			2'd0:    begin s = {"content-length", 24'h0}; n = 5'd14; end
			2'd1:    begin s = "transfer-encoding"; n = 5'd17; end
			default: begin s = {"location", 72'h0}; n = 5'd8; end
		endcase
		if (p >= n) return 8'h00;
		return s[8*(16 - p) +: 8];
	endfunction

	function automatic logic [7:0] chunked_char(input logic [3:0] p);
		logic [8*7-1:0] s;
		s = "chunked";
		if (p >= 4'd7) return 8'h00;
		return s[8*(6 - p) +: 8];
	endfunction

endpackage

/* hw/rtl/hrsp_front.sv */
module hrsp_front
	import hrsp_pkg::*;
(
	input  in_item_t  in_item,
	output cls_item_t cls_item
);
	logic [7:0] c;
	assign c = in_item.data_byte;

	always_comb begin
		cls_item = '0;
		cls_item.data_byte = c;
		cls_item.start_req = in_item.start_req;
		cls_item.sink_stop = in_item.sink_stop;
		case (c)
			8'h09:   cls_item.col_hdr = 3'd1;
			8'h0A:   cls_item.col_hdr = 3'd2;
			8'h0D:   cls_item.col_hdr = 3'd3;
			8'h20:   cls_item.col_hdr = 3'd4;
			8'h2C:   cls_item.col_hdr = 3'd5;
			8'h3A:   cls_item.col_hdr = 3'd6;
			default: cls_item.col_hdr = 3'd0;
		endcase
		cls_item.is_digit = (c >= 8'h30) && (c <= 8'h39);
		if (c == 8'h0A) cls_item.col_chk = 2'd1;
		else if (c == 8'h0D) cls_item.col_chk = 2'd2;
		else if (cls_item.is_digit) begin
			cls_item.col_chk = 2'd3; cls_item.hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			cls_item.col_chk = 2'd3; cls_item.hex_val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			cls_item.col_chk = 2'd3; cls_item.hex_val = 4'(c - 8'h37);
		end else cls_item.col_chk = 2'd0;
		cls_item.low_byte = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	end
endmodule

/* hw/rtl/hrsp_queue.sv */
module hrsp_queue
	import hrsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  cls_item_t wr_data,
	output logic      rd_valid,
	input  logic      rd_ready,
	output cls_item_t rd_data
);
	cls_item_t  mem_q [0:1];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr_en, rd_en;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule

/* hw/rtl/hrsp_back.sv */
module hrsp_back
	import hrsp_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cls_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CMAX_DIV10 = CMAX / 10;
	localparam logic [COUNT_WIDTH-1:0] CMAX_DIV16 = CMAX >> 4;

	mode_t            mode_q;
	logic [3:0]       tst_q;
	logic [9:0]       code_q;
	logic [4:0]       kpos_q;
	logic [2:0]       kflg_q;
	logic [3:0]       vpos_q;
	logic [1:0]       vflg_q;
	logic [COUNT_WIDTH-1:0] vnum_q, dlen_q, rem_q;
	logic [1:0]       cmode_q;
	logic             ovalid_q;
	out_item_t        out_q;

	mode_t            mode_d;
	logic [3:0]       tst_d;
	logic [9:0]       code_d;
	logic [4:0]       kpos_d;
	logic [2:0]       kflg_d;
	logic [3:0]       vpos_d;
	logic [1:0]       vflg_d;
	logic [COUNT_WIDTH-1:0] vnum_d, dlen_d, rem_d;
	logic [1:0]       cmode_d;
	out_item_t        res;
	logic [7:0]       act, c;
	logic [COUNT_WIDTH-1:0] d4;
	logic [13:0]      cv;
	logic             take;

	assign in_ready = !ovalid_q || out_ready;
	assign take = in_valid && in_ready;
	assign out_valid = ovalid_q;
	assign out_item = out_q;
	assign c = in_item.data_byte;

	always_comb begin
		mode_d = mode_q; tst_d = tst_q; code_d = code_q; kpos_d = kpos_q;
		kflg_d = kflg_q; vpos_d = vpos_q; vflg_d = vflg_q; vnum_d = vnum_q;
		dlen_d = dlen_q; rem_d = rem_q; cmode_d = cmode_q;
		act = 8'h00; d4 = '0; cv = '0;
		res = '0;
		res.out_byte = c;
		if (in_item.start_req) begin
			mode_d = M_HEADER; tst_d = '0; code_d = '0; kpos_d = '0; kflg_d = 3'd7;
			vpos_d = '0; vflg_d = 2'd3; vnum_d = '0; cmode_d = C_NONE;
			dlen_d = CMAX; rem_d = '0;
		end
		unique case (mode_d)
			M_HEADER: begin
				act = hdr_lookup(tst_d, in_item.col_hdr);
				tst_d = act[3:0];
				case (act)
					A_VER: res.byte_class = CL_VERSION;
					A_CODE: begin
						cv = 14'(code_d) * 14'd10 + 14'(c);
						if (cv < 14'd48) code_d = '0;
						else if (cv - 14'd48 > 14'd1023) code_d = 10'd1023;
						else code_d = 10'(cv - 14'd48);
						res.byte_class = CL_CODE;
					end
					A_RSN: res.byte_class = CL_REASON;
					A_KEY: begin
						res.out_byte = in_item.low_byte;
						if (key_char(2'd0, kpos_d) != in_item.low_byte) kflg_d[0] = 1'b0;
						if (key_char(2'd1, kpos_d) != in_item.low_byte) kflg_d[1] = 1'b0;
						if (key_char(2'd2, kpos_d) != in_item.low_byte) kflg_d[2] = 1'b0;
						if (kpos_d < 5'd31) kpos_d = kpos_d + 5'd1;
						res.byte_class = CL_KEY;
					end
					A_VAL0, A_VAL1: begin
						d4 = COUNT_WIDTH'(c[3:0]);
						if (in_item.is_digit) begin
							if (vflg_d[0]) begin
								// overflow test without a divider
								if (vnum_d > CMAX_DIV10 ||
								    (vnum_d == CMAX_DIV10 && d4 >= CMAX - CMAX_DIV10 * 10))
									vnum_d = CMAX - 1'b1;
								else vnum_d = COUNT_WIDTH'(vnum_d * 10) + d4;
							end
						end else vflg_d[0] = 1'b0;
						if (chunked_char(vpos_d) != c) vflg_d[1] = 1'b0;
						if (vpos_d < 4'd15) vpos_d = vpos_d + 4'd1;
						res.byte_class = CL_VALUE;
					end
					A_PAIR: begin
						if (kflg_d[0] && kpos_d == 5'd14) begin
							res.header_id = 2'd1;
							if (vflg_d[0] && vpos_d != 0) begin
								dlen_d = vnum_d; rem_d = vnum_d;
							end else begin
								dlen_d = CMAX; rem_d = '0;
							end
							cmode_d = C_LEN;
						end else if (kflg_d[1] && kpos_d == 5'd17) begin
							res.header_id = 2'd2;
							cmode_d = (vflg_d[1] && vpos_d == 4'd7) ? C_CHUNK : C_NONE;
						end else if (kflg_d[2] && kpos_d == 5'd8) res.header_id = 2'd3;
						kpos_d = '0; kflg_d = 3'd7; vpos_d = '0; vflg_d = 2'd3; vnum_d = '0;
						res.byte_class = CL_PAIREND;
					end
					A_DONE: begin
						res.byte_class = CL_HDONE;
						if (cmode_d == C_CHUNK) begin
							mode_d = M_CHDR; dlen_d = '0; rem_d = '0;
						end else if (cmode_d == C_NONE) mode_d = M_STREAM;
						else if (dlen_d == '0) mode_d = M_CLOSE;
						else if (dlen_d == CMAX) begin
							mode_d = M_ERROR; res.byte_class = CL_ERROR;
						end else mode_d = M_EXPECT;
					end
					A_ERR: begin
						mode_d = M_ERROR; res.byte_class = CL_ERROR;
					end
					default: res.byte_class = CL_SKIP;
				endcase
			end
			M_EXPECT: begin
				res.byte_class = CL_BODY;
				if (rem_d != '0) rem_d = rem_d - 1'b1;
				if (in_item.sink_stop || rem_d == '0) mode_d = M_CLOSE;
			end
			M_STREAM: begin
				res.byte_class = CL_BODY;
				if (in_item.sink_stop) mode_d = M_CLOSE;
			end
			M_CHDR: begin
				res.byte_class = CL_CHUNKF;
				act = chk_lookup(tst_d, in_item.col_chk);
				tst_d = act[3:0];
				d4 = COUNT_WIDTH'(in_item.hex_val);
				case (act)
					A_DONE: if (dlen_d == '0) mode_d = M_CLOSE;
					A_ERR: begin
						mode_d = M_ERROR; res.byte_class = CL_ERROR;
					end
					A_CFIRST: dlen_d = d4;
					A_CODE: begin
						if (dlen_d > CMAX_DIV16 ||
						    (dlen_d == CMAX_DIV16 && d4 > (CMAX & COUNT_WIDTH'(15))))
							dlen_d = CMAX;
						else dlen_d = {dlen_d[COUNT_WIDTH-5:0], 4'h0} + d4;
					end
					A_CSTEP: if (dlen_d != '0) begin
						mode_d = M_CDATA; rem_d = dlen_d;
					end
					default: ;
				endcase
			end
			M_CDATA: begin
				res.byte_class = CL_BODY;
				if (in_item.sink_stop) mode_d = M_CLOSE;
				else begin
					if (rem_d != '0) rem_d = rem_d - 1'b1;
					if (rem_d == '0) begin
						dlen_d = COUNT_WIDTH'(1); mode_d = M_CHDR;
					end
				end
			end
			M_CLOSE: res.byte_class = CL_CLOSED;
			default: res.byte_class = CL_ERROR;
		endcase
		res.response_code = code_d;
		if (COUNT_WIDTH > 32)
			res.bytes_left = (rem_d > COUNT_WIDTH'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(rem_d);
		else res.bytes_left = 32'(rem_d);
		res.chunked = cmode_d == C_CHUNK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_HEADER; tst_q <= '0; code_q <= '0; kpos_q <= '0; kflg_q <= 3'd7;
			vpos_q <= '0; vflg_q <= 2'd3; vnum_q <= '0; cmode_q <= C_NONE;
			dlen_q <= CMAX; rem_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= mode_d; tst_q <= tst_d; code_q <= code_d; kpos_q <= kpos_d;
				kflg_q <= kflg_d; vpos_q <= vpos_d; vflg_q <= vflg_d; vnum_q <= vnum_d;
				cmode_q <= cmode_d; dlen_q <= dlen_d; rem_q <= rem_d;
			end
			if (take) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end
endmodule

/* hw/rtl/http_response_stream_parser_core.sv */
// Path from input accept to result valid: the queue entry, then the result register.
// Throughput: one item per cycle while out_ready is high; the state update is a combinational table step.
// The two-entry queue lets the front take items while the result waits.
// Reset (arst_n low): queue empty, no result pending, parse state as after start_req.
module http_response_stream_parser_core
	import hrsp_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	cls_item_t cls, q_data;
	logic      q_valid, q_ready;

	hrsp_front u_front (.in_item(in_data), .cls_item(cls));

	hrsp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_ready(in_ready), .wr_data(cls),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	hrsp_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
	);
endmodule

/* hw/rtl/hrsp_checker.sv */
module hrsp_checker
	import hrsp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_class <= CL_ERROR)
		else $error("bad byte class");

	a_hid_only_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.header_id != 2'd0 |-> out_data.byte_class == CL_PAIREND)
		else $error("header id outside pair end");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid && in_ready) |=> !out_valid)
		else $error("result without input");
endmodule

bind http_response_stream_parser_core hrsp_checker u_hrsp_checker (.*);
